// ===== src/bmm_pkg.sv =====
package bmm_pkg;

    localparam int HISTORY_DEPTH_DEF   = 5;
    localparam int ROUNDABOUT_GAIN_DEF = 10;

    localparam int DATA_W  = 64;
    localparam int DIV_W   = 32;
    localparam int DEN_W   = 7;
    localparam int PADDR_W = 5;

    localparam logic [11:0]        DRIVE_LIMIT  = 12'd3150;
    localparam logic [12:0]        RING_LEVEL   = 13'd1050;
    localparam logic signed [15:0] PITCH_ENTRY  = -16'sd1800;
    localparam logic [7:0]         RING_OPEN    = 8'd80;
    localparam logic [7:0]         RING_CLOSE   = 8'd200;
    localparam logic [12:0]        LINE_LOW     = 13'd250;
    localparam logic [12:0]        LINE_MID     = 13'd400;
    localparam logic [12:0]        LINE_HIGH    = 13'd920;
    localparam logic [DEN_W-1:0]   DEN_HUNDRED  = 7'd100;
    localparam logic [DEN_W-1:0]   DEN_TEN      = 7'd10;

    localparam logic signed [63:0] C3_Q48 = 64'sd1419478;
    localparam logic signed [63:0] C2_Q48 = -64'sd802203684;
    localparam logic signed [63:0] C1_Q48 = 64'sd3380514470295;
    localparam logic signed [63:0] C0_Q48 = -64'sd1800313951041;
    localparam logic signed [63:0] ROUND_HALF = 64'sd2147483648;
    localparam logic signed [63:0] LOST_LINE_X = 64'sd851968;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef enum logic [2:0] {
        REG_ANGLE_P,
        REG_ANGLE_D,
        REG_TARGET_PITCH,
        REG_TARGET_SPEED,
        REG_SPEED_P,
        REG_SPEED_I,
        REG_TURN_P,
        REG_TURN_D
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_SUM,
        ST_ANG_P,
        ST_ANG_D,
        ST_ANG_DIV,
        ST_SPD_P,
        ST_SPD_I,
        ST_SPD_DIV,
        ST_RING_DIV,
        ST_DIFF,
        ST_E2,
        ST_E3,
        ST_C3,
        ST_C2,
        ST_C1,
        ST_ROUND,
        ST_TURN_P,
        ST_TURN_D,
        ST_FINISH
    } seq_state_t;

    // Exact floor(v / 10) for every 10-bit v.
    function automatic logic [6:0] div_by_ten(input logic [9:0] v);
        logic [17:0] t;
        t = 18'(v) * 18'd205;
        return t[17:11];
    endfunction

endpackage

// ===== src/bmm_in_if.sv =====
interface bmm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch;
    logic signed [15:0] gyro_rate;
    logic [15:0]        enc_left_count;
    logic               enc_left_dir;
    logic [15:0]        enc_right_count;
    logic               enc_right_dir;
    logic [11:0]        ind_left;
    logic [11:0]        ind_right;

    modport source (output valid, pitch, gyro_rate, enc_left_count, enc_left_dir,
                    enc_right_count, enc_right_dir, ind_left, ind_right, input ready);
    modport sink (input valid, pitch, gyro_rate, enc_left_count, enc_left_dir,
                  enc_right_count, enc_right_dir, ind_left, ind_right, output ready);
endinterface

// ===== src/bmm_out_if.sv =====
interface bmm_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] left_magnitude;
    logic        left_forward;
    logic [11:0] right_magnitude;
    logic        right_forward;
    logic        beep;

    modport source (output valid, left_magnitude, left_forward, right_magnitude,
                    right_forward, beep, input ready);
    modport sink (input valid, left_magnitude, left_forward, right_magnitude,
                  right_forward, beep, output ready);
endinterface

// ===== src/balance_car_motor_mixer_unit.sv =====
// Motor mixer for a two-wheel balancing car. One sensor beat per control tick
// gives one motor beat with both wheel magnitudes (saturated at 3150), their
// direction bits and the roundabout beep flag. All products go through one
// shift-add multiplier that retires one bit of its operand b per cycle,
// and the divisions by 100 and 10 go through one restoring divider. A tick
// adds up the HISTORY_DEPTH entries of the speed error window in turn;
// smaller gains and readings shorten the multiplies. A new sensor beat is
// taken once the previous result sits in the output register.
// Registers are written over the APB port at byte address 4*index.
module balance_car_motor_mixer_unit
    import bmm_pkg::*;
#(
    parameter int HISTORY_DEPTH   = HISTORY_DEPTH_DEF,
    parameter int ROUNDABOUT_GAIN = ROUNDABOUT_GAIN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    bmm_in_if.sink             sensor,
    bmm_out_if.source          motor
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = 17 + IDX_W;

    // Configuration registers
    logic [9:0]         angle_p_reg, angle_d_reg, speed_p_reg, speed_i_reg;
    logic [9:0]         turn_p_reg, turn_d_reg;
    logic signed [14:0] target_pitch_reg;
    logic signed [10:0] target_speed_reg;
    reg_index_t         widx;

    assign pready = 1'b1;
    assign widx   = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_p_reg      <= '0;
            angle_d_reg      <= '0;
            target_pitch_reg <= '0;
            target_speed_reg <= '0;
            speed_p_reg      <= '0;
            speed_i_reg      <= '0;
            turn_p_reg       <= '0;
            turn_d_reg       <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_ANGLE_P:      angle_p_reg      <= pwdata[9:0];
                REG_ANGLE_D:      angle_d_reg      <= pwdata[9:0];
                REG_TARGET_PITCH: target_pitch_reg <= pwdata[14:0];
                REG_TARGET_SPEED: target_speed_reg <= pwdata[10:0];
                REG_SPEED_P:      speed_p_reg      <= pwdata[9:0];
                REG_SPEED_I:      speed_i_reg      <= pwdata[9:0];
                REG_TURN_P:       turn_p_reg       <= pwdata[9:0];
                REG_TURN_D:       turn_d_reg       <= pwdata[9:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_ANGLE_P:      prdata = 32'(angle_p_reg);
            REG_ANGLE_D:      prdata = 32'(angle_d_reg);
            REG_TARGET_PITCH: prdata = 32'(unsigned'(target_pitch_reg));
            REG_TARGET_SPEED: prdata = 32'(unsigned'(target_speed_reg));
            REG_SPEED_P:      prdata = 32'(speed_p_reg);
            REG_SPEED_I:      prdata = 32'(speed_i_reg);
            REG_TURN_P:       prdata = 32'(turn_p_reg);
            REG_TURN_D:       prdata = 32'(turn_d_reg);
        endcase
    end

    // Shared arithmetic units
    logic                     mul_start, div_start;
    logic signed [DATA_W-1:0] mul_a, mul_b, mul_prod, div_num, div_quo;
    logic [DEN_W-1:0]         div_den;
    unit_status_t             mul_st, div_st;

    bmm_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .prod   (mul_prod),
        .status (mul_st)
    );

    bmm_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quo    (div_quo),
        .status (div_st)
    );

    // Sequencer and state
    seq_state_t         state_reg, state_next;
    logic               issued_reg, issued_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [15:0] hist_reg [HISTORY_DEPTH];
    logic [7:0]         ring_cnt_reg;
    logic               ring_on_reg;
    logic signed [15:0] last_e_reg;
    logic               out_valid_reg;

    // Work registers
    logic signed [15:0]       pitch_reg, gyro_reg;
    logic [15:0]              cl_reg, cr_reg;
    logic                     dl_reg, dr_reg;
    logic [12:0]              indl_reg;
    logic [11:0]              indr_reg;
    logic signed [15:0]       err_reg, e_reg;
    logic signed [16:0]       dpitch_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     beep_reg;
    logic signed [DATA_W-1:0] acc_reg, tacc_reg, angle_reg, speed_reg;
    logic signed [DATA_W-1:0] e2_reg, e3_reg, x_reg;

    logic [11:0] lmag_reg, rmag_reg;
    logic        lfwd_reg, rfwd_reg, obeep_reg;

    logic               accept, unit_done, finish_go;
    logic signed [15:0] encl, encr, err_w;
    logic signed [16:0] enc_sum, enc_mean;
    logic [7:0]         cnt1;
    logic               entry;
    logic [17:0]        ring_scaled;
    logic [6:0]         d_tenth;
    logic signed [DATA_W-1:0] rounded, turn, lmix, rmix, labs, rabs;
    logic                     lost_left, lost_right;

    assign accept    = sensor.valid && sensor.ready;
    assign unit_done = issued_reg && (mul_st.done || div_st.done);
    assign finish_go = state_reg == ST_FINISH && (!out_valid_reg || motor.ready);
    assign sensor.ready = state_reg == ST_IDLE;

    // Signed encoder counts and the speed error of this tick
    assign encl     = dl_reg ? $signed(cl_reg) : $signed(16'(-cl_reg));
    assign encr     = dr_reg ? $signed(16'(-cr_reg)) : $signed(cr_reg);
    assign enc_sum  = 17'(encl) + 17'(encr);
    assign enc_mean = $signed(enc_sum + 17'(enc_sum[16])) >>> 1;
    assign err_w    = 16'(17'(target_speed_reg) - enc_mean);

    // Roundabout entry uses the counter after this tick's increment.
    assign cnt1  = ring_on_reg ? 8'(ring_cnt_reg + 1'b1) : ring_cnt_reg;
    assign entry = indr_reg > RING_LEVEL[11:0] && pitch_reg < PITCH_ENTRY
                   && indl_reg > RING_LEVEL && cnt1 < RING_OPEN;

    assign ring_scaled = 18'(indl_reg) * 18'(ROUNDABOUT_GAIN);
    assign d_tenth     = div_by_ten(angle_d_reg);

    assign lost_left  = indl_reg < LINE_LOW && indr_reg < LINE_HIGH[11:0]
                        && indr_reg > LINE_LOW[11:0];
    assign lost_right = indl_reg > LINE_MID && indl_reg < LINE_HIGH
                        && indr_reg < LINE_MID[11:0];
    assign rounded    = (acc_reg + C0_Q48 + ROUND_HALF) >>> 32;

    assign turn = tacc_reg[DATA_W-1] ? (tacc_reg + 64'sd65535) >>> 16 : tacc_reg >>> 16;
    assign lmix = angle_reg + speed_reg - turn;
    assign rmix = angle_reg + speed_reg + turn;
    assign labs = lmix[DATA_W-1] ? -lmix : lmix;
    assign rabs = rmix[DATA_W-1] ? -rmix : rmix;

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        idx_next    = idx_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_num     = '0;
        div_den     = DEN_HUNDRED;
        unique case (state_reg)
            ST_IDLE:
                if (sensor.valid)
                    state_next = ST_PREP;
            ST_PREP:
            begin
                idx_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
                if (idx_reg == IDX_W'(HISTORY_DEPTH - 1))
                    state_next = ST_ANG_P;
                else
                    idx_next = idx_reg + 1'b1;
            ST_ANG_P:
            begin
                mul_a = DATA_W'(dpitch_reg);
                mul_b = DATA_W'(angle_p_reg);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_ANG_D;
            end
            ST_ANG_D:
            begin
                mul_a = DATA_W'(gyro_reg);
                mul_b = DATA_W'(14'(d_tenth) * 14'd100);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_ANG_DIV;
            end
            ST_ANG_DIV:
            begin
                div_num = acc_reg;
                div_start = !issued_reg;
                if (unit_done)
                    state_next = ST_SPD_P;
            end
            ST_SPD_P:
            begin
                mul_a = DATA_W'(err_reg);
                mul_b = DATA_W'(speed_p_reg);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_SPD_I;
            end
            ST_SPD_I:
            begin
                mul_a = DATA_W'(sum_reg);
                mul_b = DATA_W'(speed_i_reg);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_SPD_DIV;
            end
            ST_SPD_DIV:
            begin
                div_num = tacc_reg;
                div_start = !issued_reg;
                if (unit_done)
                    state_next = beep_reg ? ST_RING_DIV : ST_DIFF;
            end
            ST_RING_DIV:
            begin
                div_num = DATA_W'(ring_scaled);
                div_den = DEN_TEN;
                div_start = !issued_reg;
                if (unit_done)
                    state_next = ST_DIFF;
            end
            ST_DIFF:
                state_next = ST_E2;
            ST_E2:
            begin
                mul_a = DATA_W'(e_reg);
                mul_b = DATA_W'(e_reg);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_E3;
            end
            ST_E3:
            begin
                mul_a = e2_reg;
                mul_b = DATA_W'(e_reg);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_C3;
            end
            ST_C3:
            begin
                mul_a = e3_reg;
                mul_b = C3_Q48;
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_C2;
            end
            ST_C2:
            begin
                mul_a = C2_Q48;
                mul_b = e2_reg;
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_C1;
            end
            ST_C1:
            begin
                mul_a = C1_Q48;
                mul_b = DATA_W'(e_reg);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
                state_next = ST_TURN_P;
            ST_TURN_P:
            begin
                mul_a = x_reg;
                mul_b = DATA_W'(turn_p_reg);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_TURN_D;
            end
            ST_TURN_D:
            begin
                mul_a = DATA_W'(17'(e_reg) - 17'(last_e_reg));
                mul_b = DATA_W'(turn_d_reg);
                mul_start = !issued_reg;
                if (unit_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
                if (!out_valid_reg || motor.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        if (mul_start || div_start)
            issued_next = 1'b1;
        if (state_next != state_reg)
            issued_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            idx_reg       <= '0;
            ring_cnt_reg  <= '0;
            ring_on_reg   <= 1'b0;
            last_e_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            idx_reg    <= idx_next;
            if (state_reg == ST_PREP)
            begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                    hist_reg[i] <= hist_reg[i-1];
                hist_reg[0] <= err_w;
                if (entry)
                begin
                    ring_on_reg  <= 1'b1;
                    ring_cnt_reg <= cnt1;
                end
                else if (cnt1 > RING_CLOSE)
                begin
                    ring_on_reg  <= 1'b0;
                    ring_cnt_reg <= '0;
                end
                else
                    ring_cnt_reg <= cnt1;
            end
            if (finish_go)
            begin
                last_e_reg    <= e_reg;
                out_valid_reg <= 1'b1;
            end
            else if (motor.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pitch_reg <= sensor.pitch;
            gyro_reg  <= sensor.gyro_rate;
            cl_reg    <= sensor.enc_left_count;
            dl_reg    <= sensor.enc_left_dir;
            cr_reg    <= sensor.enc_right_count;
            dr_reg    <= sensor.enc_right_dir;
            indl_reg  <= 13'(sensor.ind_left);
            indr_reg  <= sensor.ind_right;
        end
        unique case (state_reg)
            ST_PREP:
            begin
                err_reg    <= err_w;
                dpitch_reg <= 17'(pitch_reg) - 17'(target_pitch_reg);
                sum_reg    <= '0;
                beep_reg   <= entry;
            end
            ST_SUM:
                sum_reg <= sum_reg + SUM_W'(hist_reg[idx_reg]);
            ST_ANG_P, ST_SPD_P, ST_C3:
                if (unit_done)
                    acc_reg <= mul_prod;
            ST_ANG_D, ST_C2, ST_C1:
                if (unit_done)
                    acc_reg <= acc_reg + mul_prod;
            ST_ANG_DIV:
                if (unit_done)
                    angle_reg <= div_quo;
            ST_SPD_I, ST_TURN_P:
                if (unit_done)
                    tacc_reg <= mul_prod;
            ST_SPD_DIV:
                if (unit_done)
                    speed_reg <= div_quo - acc_reg;
            ST_RING_DIV:
                if (unit_done)
                    indl_reg <= div_quo[12:0];
            ST_DIFF:
                e_reg <= 16'(17'(indr_reg) - 17'(indl_reg));
            ST_E2:
                if (unit_done)
                    e2_reg <= mul_prod;
            ST_E3:
                if (unit_done)
                    e3_reg <= mul_prod;
            ST_ROUND:
                // The right-side override wins over the left-side one.
                if (lost_right)
                    x_reg <= LOST_LINE_X;
                else if (lost_left)
                    x_reg <= -LOST_LINE_X;
                else
                    x_reg <= rounded;
            ST_TURN_D:
                if (unit_done)
                    tacc_reg <= tacc_reg + (mul_prod <<< 16);
            default:
                ;
        endcase
        if (finish_go)
        begin
            lfwd_reg  <= lmix[DATA_W-1];
            rfwd_reg  <= rmix[DATA_W-1];
            lmag_reg  <= (labs >= DATA_W'(DRIVE_LIMIT)) ? DRIVE_LIMIT : labs[11:0];
            rmag_reg  <= (rabs >= DATA_W'(DRIVE_LIMIT)) ? DRIVE_LIMIT : rabs[11:0];
            obeep_reg <= beep_reg;
        end
    end

    assign motor.valid           = out_valid_reg;
    assign motor.left_magnitude  = lmag_reg;
    assign motor.left_forward    = lfwd_reg;
    assign motor.right_magnitude = rmag_reg;
    assign motor.right_forward   = rfwd_reg;
    assign motor.beep            = obeep_reg;

    // Only one arithmetic unit runs at a time.
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_st.busy && div_st.busy))
        else $error("multiplier and divider busy together");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        motor.valid |-> (motor.left_magnitude <= DRIVE_LIMIT
                         && motor.right_magnitude <= DRIVE_LIMIT))
        else $error("drive magnitude above limit");

    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (sensor.valid && sensor.ready) |=> !sensor.ready)
        else $error("second sensor beat taken during a tick");

endmodule

// ===== src/bmm_mul.sv =====
module bmm_mul
    import bmm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic signed [DATA_W-1:0] prod,
    output unit_status_t             status
);

    logic              busy_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] ma_reg;
    logic [DATA_W-1:0] mb_reg;
    logic [DATA_W-1:0] acc_reg;

    // The multiplier operand b is consumed one bit per cycle, so the run
    // ends as soon as its remaining bits are all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (busy_reg && mb_reg == '0)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            ma_reg  <= a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
            mb_reg  <= b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
            acc_reg <= '0;
        end
        else if (busy_reg && mb_reg != '0)
        begin
            if (mb_reg[0])
                acc_reg <= acc_reg + ma_reg;
            ma_reg <= {ma_reg[DATA_W-2:0], 1'b0};
            mb_reg <= {1'b0, mb_reg[DATA_W-1:1]};
        end
    end

    assign prod        = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
    assign status.busy = busy_reg;
    assign status.done = busy_reg && mb_reg == '0;

endmodule

// ===== src/bmm_div.sv =====
module bmm_div
    import bmm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic [DEN_W-1:0]         den,
    output logic signed [DATA_W-1:0] quo,
    output unit_status_t             status
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W+1:0] trial;
    logic [DATA_W-1:0] mag;

    assign mag   = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign trial = {rem_reg, q_reg[DIV_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Restoring division: one quotient bit per cycle, the remainder stays
    // below the divisor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[DATA_W-1];
            q_reg   <= mag[DIV_W-1:0];
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (trial >= {2'b00, den_reg})
            begin
                rem_reg <= (DEN_W+1)'(trial - {2'b00, den_reg});
                q_reg   <= {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DEN_W:0];
                q_reg   <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign quo = neg_reg ? -$signed(DATA_W'(q_reg)) : $signed(DATA_W'(q_reg));
    assign status.busy = busy_reg;
    assign status.done = busy_reg && cnt_reg == '0;

endmodule
